FILE: hw/rtl/qlp_pkg.sv
// Shared types, constants and helpers for the quoted literal parser.
package qlp_pkg;

  localparam int QLP_COUNT_WIDTH_DEF = 16;
  localparam int QLP_FIELD_W         = 16;
  localparam int QLP_TDATA_W         = 56;
  localparam int QLP_TUSER_W         = 2;
  localparam logic [7:0] QLP_HIGH_BIT = 8'h80;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [15:0] char_count;
    logic [15:0] byte_count;
    logic [15:0] consumed_len;
    logic        last;
  } result_t;

  // Continuation bytes that follow a UTF-8 lead byte (high bit set).
  function automatic logic [2:0] cont_len(input logic [7:0] b);
    logic [2:0] n;
    if (b < 8'hE0)      n = 3'd1;
    else if (b < 8'hF0) n = 3'd2;
    else if (b < 8'hF8) n = 3'd3;
    else if (b < 8'hFC) n = 3'd4;
    else                n = 3'd5;
    return n;
  endfunction

endpackage

FILE: hw/rtl/qlp_step.sv
// Per-byte literal state machine: holds the parse state and forms one result.
module qlp_step import qlp_pkg::*; #(
  parameter int COUNT_WIDTH = QLP_COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] src_byte,
  input  logic       dq_en,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_INSIDE = 2'd1,
    PH_QUOTE  = 2'd2
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_t                 phase, phase_next;
  logic [7:0]             quote_char, quote_char_next;
  logic [2:0]             cont_left, cont_left_next;
  logic [COUNT_WIDTH-1:0] chars_seen, chars_seen_next;
  logic [COUNT_WIDTH-1:0] bytes_out, bytes_out_next;
  logic [COUNT_WIDTH-1:0] bytes_consumed, bytes_consumed_next;
  logic                   emit;
  kind_t                  emit_kind;

  logic [COUNT_WIDTH+QLP_FIELD_W-1:0] chars_ext, bytes_ext, cons_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    phase_next          = phase;
    quote_char_next     = quote_char;
    cont_left_next      = cont_left;
    chars_seen_next     = chars_seen;
    bytes_out_next      = bytes_out;
    bytes_consumed_next = bytes_consumed;
    emit                = 1'b0;
    emit_kind           = KIND_TEXT;
    unique case (phase)
      PH_QUOTE: begin
        if (src_byte == quote_char && dq_en) begin
          // doubled quote stands for one literal quote
          phase_next          = PH_INSIDE;
          chars_seen_next     = sat_inc(chars_seen);
          bytes_out_next      = sat_inc(bytes_out);
          bytes_consumed_next = sat_inc(bytes_consumed);
          emit                = 1'b1;
        end else begin
          // closing byte is dropped
          phase_next     = PH_IDLE;
          cont_left_next = 3'd0;
          emit           = 1'b1;
          emit_kind      = KIND_END;
        end
      end
      PH_INSIDE: begin
        if (cont_left != 3'd0) begin
          cont_left_next      = cont_left - 3'd1;
          bytes_out_next      = sat_inc(bytes_out);
          bytes_consumed_next = sat_inc(bytes_consumed);
          emit                = 1'b1;
        end else if (src_byte == 8'd0) begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          emit_kind  = KIND_ERR;
        end else if (src_byte == quote_char) begin
          bytes_consumed_next = sat_inc(bytes_consumed);
          if (dq_en) begin
            phase_next = PH_QUOTE;
          end else begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            emit_kind  = KIND_END;
          end
        end else begin
          if ((src_byte & QLP_HIGH_BIT) != 8'd0) begin
            cont_left_next = cont_len(src_byte);
          end
          chars_seen_next     = sat_inc(chars_seen);
          bytes_out_next      = sat_inc(bytes_out);
          bytes_consumed_next = sat_inc(bytes_consumed);
          emit                = 1'b1;
        end
      end
      default: begin
        // opening quote, whatever its value
        phase_next          = PH_INSIDE;
        quote_char_next     = src_byte;
        cont_left_next      = 3'd0;
        chars_seen_next     = '0;
        bytes_out_next      = '0;
        bytes_consumed_next = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
    endcase
  end

  assign chars_ext = {{QLP_FIELD_W{1'b0}}, chars_seen_next};
  assign bytes_ext = {{QLP_FIELD_W{1'b0}}, bytes_out_next};
  assign cons_ext  = {{QLP_FIELD_W{1'b0}}, bytes_consumed_next};

  assign res_valid        = accept && emit;
  assign res.kind         = emit_kind;
  assign res.text_byte    = (emit_kind == KIND_TEXT) ? src_byte : 8'd0;
  assign res.char_count   = chars_ext[QLP_FIELD_W-1:0];
  assign res.byte_count   = bytes_ext[QLP_FIELD_W-1:0];
  assign res.consumed_len = cons_ext[QLP_FIELD_W-1:0];
  assign res.last         = (emit_kind != KIND_TEXT);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      quote_char     <= 8'd0;
      cont_left      <= 3'd0;
      chars_seen     <= '0;
      bytes_out      <= '0;
      bytes_consumed <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      quote_char     <= quote_char_next;
      cont_left      <= cont_left_next;
      chars_seen     <= chars_seen_next;
      bytes_out      <= bytes_out_next;
      bytes_consumed <= bytes_consumed_next;
    end
  end

endmodule

FILE: hw/rtl/qlp_obuf.sv
// Output register with a skid stage so the input side never waits on m_tready directly.
module qlp_obuf import qlp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    main_take;

  assign in_ready  = !skid_valid;
  assign main_take = !main_valid || out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_take) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: hw/rtl/quoted_literal_parser_unit.sv
// Top level of the quoted literal parser.
//
// Source bytes enter on the s_axis channel, one item per byte. The first byte
// after idle opens a literal and is taken as its quote character. Each byte
// inside the literal gives one text item on m_axis (tuser = kind, tlast low);
// the byte after a closing quote (or the quote itself when doubling is off),
// or a NUL, gives a single end or error item with tlast high and is consumed.
// tdata carries the text byte and the running character, byte and consumed
// counts.
// Throughput is one byte per cycle while s_axis_tready is high: the decision
// for a byte is made in the cycle it is accepted and written into the output
// register, or into the skid stage when the output register is stalled.
// The output register is backed by a one-item skid stage; s_axis_tready
// drops only once that skid item is held, i.e. after two results back up
// while m_axis_tready is low. No item is lost or repeated under stall.
// cfg_we writes the doubled-quote enable; use it only while the block is idle.
// Reset (rst, synchronous) returns to idle, clears counts and output items,
// and sets the doubled-quote enable.
module quoted_literal_parser_unit import qlp_pkg::*; #(
  parameter int COUNT_WIDTH = QLP_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // src_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [QLP_TDATA_W-1:0] m_axis_tdata,   // text_byte, char_count, byte_count,
                                                 // consumed_len
  output logic [QLP_TUSER_W-1:0] m_axis_tuser,   // kind
  output logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata       // doubled_quote_enable
);

  logic    dq_en;
  logic    accept;
  logic    res_valid;
  result_t res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_en <= 1'b1;
    end else if (cfg_we) begin
      dq_en <= cfg_wdata;
    end
  end

  qlp_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .src_byte  (s_axis_tdata),
    .dq_en     (dq_en),
    .res_valid (res_valid),
    .res       (res)
  );

  qlp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {out_res.consumed_len, out_res.byte_count,
                         out_res.char_count, out_res.text_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

FILE: hw/rtl/qlp_checker.sv
// Port-level checks for the quoted literal parser, bound to the top level.
module qlp_checker import qlp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [QLP_TDATA_W-1:0] m_axis_tdata,
  input logic [QLP_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tlast
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output item changed under stall");

  // end and error items carry tlast, text items never do
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_TEXT)))
    else $error("tlast does not match kind");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == KIND_TEXT || m_axis_tuser == KIND_END
                       || m_axis_tuser == KIND_ERR))
    else $error("unused kind code on output");

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'd0)
    else $error("end item carries a text byte");

  // the input side only backs up once output items are waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

endmodule

bind quoted_literal_parser_unit qlp_checker u_qlp_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the quoted literal parser unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qlp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 240;

  typedef enum logic [1:0] {
    LIT_IDLE,
    LIT_BODY,
    LIT_AFTER_QUOTE
  } lit_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [QLP_TDATA_W-1:0] m_axis_tdata;
  logic [QLP_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;

  quoted_literal_parser_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lexer state mirrored on the testbench side
  lit_phase_t  lex_phase = LIT_IDLE;
  logic [7:0]  lex_quote = '0;
  logic [2:0]  lex_tail = '0;
  logic [15:0] lex_chars = '0;
  logic [15:0] lex_bytes = '0;
  logic [15:0] lex_consumed = '0;
  logic        dq_en = 1'b1;

  logic [7:0] src_bytes [$];
  result_t    lit_results [$];

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_closed = 0;
  int n_unterm = 0;
  int n_queued = 0;
  int cycles = 0;

  // Continuation bytes implied by a lead byte with the high bit set
  function automatic logic [2:0] utf8_tail(input logic [7:0] lead);
    casez (lead)
      8'b1110????: return 3'd2;
      8'b11110???: return 3'd3;
      8'b111110??: return 3'd4;
      8'b111111??: return 3'd5;
      default:     return 3'd1;
    endcase
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic emit_result(input kind_t k, input logic [7:0] b, input logic last);
    result_t r;
    r.kind         = k;
    r.text_byte    = b;
    r.char_count   = lex_chars;
    r.byte_count   = lex_bytes;
    r.consumed_len = lex_consumed;
    r.last         = last;
    lit_results.push_back(r);
  endtask

  task automatic emit_text(input logic [7:0] b, input logic new_char);
    if (new_char) lex_chars = sat_inc(lex_chars);
    lex_bytes    = sat_inc(lex_bytes);
    lex_consumed = sat_inc(lex_consumed);
    emit_result(KIND_TEXT, b, 1'b0);
  endtask

  task automatic close_literal(input kind_t k);
    lex_phase = LIT_IDLE;
    lex_tail  = '0;
    emit_result(k, 8'h00, 1'b1);
  endtask

  task automatic lex_byte(input logic [7:0] b);
    case (lex_phase)
      LIT_AFTER_QUOTE: begin
        if (b == lex_quote && dq_en) begin
          lex_phase = LIT_BODY;
          emit_text(b, 1'b1);
        end else begin
          close_literal(KIND_END);
        end
      end
      LIT_BODY: begin
        if (lex_tail != 0) begin
          lex_tail = lex_tail - 3'd1;
          emit_text(b, 1'b0);
        end else if (b == 8'h00) begin
          close_literal(KIND_ERR);
        end else if (b == lex_quote) begin
          lex_consumed = sat_inc(lex_consumed);
          if (dq_en) lex_phase = LIT_AFTER_QUOTE;
          else close_literal(KIND_END);
        end else begin
          if (b[7]) lex_tail = utf8_tail(b);
          emit_text(b, 1'b1);
        end
      end
      default: begin
        // opening byte becomes the quote character
        lex_phase    = LIT_BODY;
        lex_quote    = b;
        lex_tail     = '0;
        lex_chars    = '0;
        lex_bytes    = '0;
        lex_consumed = 16'd1;
      end
    endcase
  endtask

  // Source driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_byte(s_axis_tdata);
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_bytes.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= src_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lit_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual tuser %h tdata %h",
                   $realtime, m_axis_tuser, m_axis_tdata);
        end else begin
          want = lit_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
          check_field("text_byte", 16'(want.text_byte), 16'(m_axis_tdata[7:0]));
          check_field("char_count", want.char_count, m_axis_tdata[23:8]);
          check_field("byte_count", want.byte_count, m_axis_tdata[39:24]);
          check_field("consumed_len", want.consumed_len, m_axis_tdata[55:40]);
          check_field("last", 16'(want.last), 16'(m_axis_tlast));
          n_checked++;
          if (want.kind == KIND_END) n_closed++;
          if (want.kind == KIND_ERR) n_unterm++;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               lit_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    src_bytes.push_back(b);
    n_queued++;
  endtask

  // Wait for the source queue and every expected result to drain
  task automatic drain();
    while (src_bytes.size() > 0 || s_axis_tvalid || lit_results.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    dq_en     = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic gen_literal();
    logic [7:0] q;
    logic [7:0] t;
    logic [2:0] tail;
    int r;
    int body;
    r = $urandom_range(0, 99);
    if (r < 50)      q = 8'h22;
    else if (r < 60) q = 8'h27;
    else if (r < 63) q = 8'h00;
    else             q = 8'($urandom_range(0, 255));
    put(q);
    body = $urandom_range(0, 10);
    repeat (body) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        t = 8'($urandom_range(1, 127));
        put((t == q) ? t ^ 8'h01 : t);
      end else if (r < 72) begin
        t = 8'($urandom_range(128, 255));
        put(t);
        tail = utf8_tail(t);
        repeat (tail) begin
          r = $urandom_range(0, 99);
          if (r < 80)      put({2'b10, 6'($urandom_range(0, 63))});
          else if (r < 90) put(8'h00);
          else             put(q);
        end
      end else if (r < 84) begin
        put(q);
        put(q);
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put(q);
      t = 8'($urandom_range(0, 255));
      put((t == q) ? t ^ 8'h01 : t);
    end else if (r < 85) begin
      put(8'h00);
    end
  endtask

  task automatic random_phase();
    int since_pause;
    since_pause = 0;
    n_queued = 0;
    while (n_queued < PHASE_ITEMS) begin
      gen_literal();
      if (n_queued - since_pause > 80) begin
        drain();
        since_pause = n_queued;
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 16;
    dst_idle_pct = 86;
    cfg_write(1'b1);

    // plain text, doubled quote, quote and NUL as continuation, six-byte lead
    put(8'h22); put(8'h41); put(8'h22); put(8'h22); put(8'hC3); put(8'h22);
    put(8'hE2); put(8'h00); put(8'h80); put(8'hFF); put(8'h80); put(8'h80);
    put(8'h80); put(8'h80); put(8'h80); put(8'h22); put(8'h2C);
    // NUL as quote character runs into the unterminated case
    put(8'h00); put(8'h7F); put(8'h00);
    // quote character with the high bit set
    put(8'hA7); put(8'h31); put(8'hA7); put(8'h41);
    drain();

    cfg_write(1'b0);
    put(8'h22); put(8'h41); put(8'h22); put(8'h22); put(8'h22);
    put(8'h27); put(8'h61);
    drain();
    // enable flips with a literal still open
    cfg_write(1'b1);
    random_phase();

    cfg_write(1'b0);
    src_idle_pct = 86;
    dst_idle_pct = 16;
    random_phase();

    cfg_write(1'b1);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_phase();

    $display("%0d source items sent, %0d results checked: %0d literals closed, %0d unterminated",
             n_sent, n_checked, n_closed, n_unterm);
    $display("doubled quotes on and off, stalls on either side and none, NULs and quotes mid-char");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
